>>> rtl/rieu_pkg.sv
// Package for the integer execute unit: payload words, opcodes, status codes.
// No dependencies.
package rieu_pkg;

  localparam int MEM_BYTES_DEF = 4096;

  localparam logic [1:0] MODE_EXEC = 2'd0;
  localparam logic [1:0] MODE_PRELOAD = 2'd1;
  localparam logic [1:0] MODE_SETPC = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;
  localparam logic [1:0] ST_SYSCALL = 2'd3;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J = 6'h02;
  localparam logic [5:0] OP_JAL = 6'h03;
  localparam logic [5:0] OP_BEQ = 6'h04;
  localparam logic [5:0] OP_BNE = 6'h05;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI = 6'h0A;
  localparam logic [5:0] OP_SLTIU = 6'h0B;
  localparam logic [5:0] OP_ANDI = 6'h0C;
  localparam logic [5:0] OP_ORI = 6'h0D;
  localparam logic [5:0] OP_XORI = 6'h0E;
  localparam logic [5:0] OP_LUI = 6'h0F;
  localparam logic [5:0] OP_LB = 6'h20;
  localparam logic [5:0] OP_LH = 6'h21;
  localparam logic [5:0] OP_LW = 6'h23;
  localparam logic [5:0] OP_LBU = 6'h24;
  localparam logic [5:0] OP_LHU = 6'h25;
  localparam logic [5:0] OP_SB = 6'h28;
  localparam logic [5:0] OP_SH = 6'h29;
  localparam logic [5:0] OP_SW = 6'h2B;

  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_SRL = 6'h02;
  localparam logic [5:0] FN_SRA = 6'h03;
  localparam logic [5:0] FN_JR = 6'h08;
  localparam logic [5:0] FN_JALR = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR = 6'h25;
  localparam logic [5:0] FN_XOR = 6'h26;
  localparam logic [5:0] FN_NOR = 6'h27;
  localparam logic [5:0] FN_SLT = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  localparam logic [31:0] PC_REGION_MASK = 32'hF000_0000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] instr_word;
    logic [11:0] preload_addr;
    logic [31:0] preload_data;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] next_pc;
    logic        reg_write_en;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        store_en;
    logic [11:0] store_addr;
    logic [31:0] store_data;
    logic [2:0]  store_size;
  } out_word_t;

  // Operation class chosen by the front end
  typedef enum logic [3:0] {
    K_NOP, K_PRELOAD, K_SETPC, K_ILLEGAL, K_SYSCALL, K_ALU, K_MULT,
    K_JUMP, K_BRANCH, K_LOAD, K_STORE
  } kind_t;

  // Decoded word handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [31:0] instr_word;
    logic [11:0] preload_addr;
    logic [31:0] preload_data;
  } dec_word_t;

endpackage

>>> rtl/rieu_front.sv
// Front end: accepts input words, classifies them, pushes into a two-entry queue.
// Depends on rieu_pkg.
module rieu_front import rieu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      q_valid,
  input  logic      q_pop,
  output dec_word_t q_data
);

  dec_word_t   q_mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  dec_word_t   dec;
  logic [5:0]  op, fn;
  logic        push;

  assign op = in_data.instr_word[31:26];
  assign fn = in_data.instr_word[5:0];

  // Classify the word
  always_comb begin
    dec.instr_word = in_data.instr_word;
    dec.preload_addr = in_data.preload_addr;
    dec.preload_data = in_data.preload_data;
    dec.kind = K_NOP;
    case (in_data.mode)
      MODE_PRELOAD: dec.kind = K_PRELOAD;
      MODE_SETPC:   dec.kind = K_SETPC;
      MODE_EXEC: begin
        if (op == OP_SPECIAL) begin
          case (fn) inside
            FN_SYSCALL: dec.kind = K_SYSCALL;
            FN_MULT, FN_MULTU: dec.kind = K_MULT;
            FN_JR: dec.kind = K_JUMP;
            FN_AND, FN_OR, FN_XOR, FN_NOR, FN_ADDU, FN_SUBU, FN_SLT, FN_SLTU,
            FN_SLL, FN_SRL, FN_SRA, FN_JALR, FN_MFHI, FN_MFLO: dec.kind = K_ALU;
            default: dec.kind = K_ILLEGAL;
          endcase
        end else begin
          case (op) inside
            OP_J, OP_JAL: dec.kind = K_JUMP;
            OP_BEQ, OP_BNE: dec.kind = K_BRANCH;
            OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI:
              dec.kind = K_ALU;
            OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: dec.kind = K_LOAD;
            OP_SB, OP_SH, OP_SW: dec.kind = K_STORE;
            default: dec.kind = K_ILLEGAL;
          endcase
        end
      end
      default: dec.kind = K_NOP;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = q_mem_r[rp_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= dec;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_ready) else $error("accept while full");

endmodule

>>> rtl/rieu_back.sv
// Back end: register file, HI/LO, PC, byte memory and the execute sequencer.
// Depends on rieu_pkg.
module rieu_back import rieu_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_pop,
  input  dec_word_t q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int WW = AW - 2;
  localparam int WORDS = MEM_BYTES / 4;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_MUL, S_OUT} state_t;

  state_t      state_r;
  logic [31:0] gpr_r [32];
  logic [31:0] pc_r, hi_r, lo_r;
  logic [31:0] mem_r [WORDS];
  logic [WW:0] clr_r;

  dec_word_t   cur_r;
  logic [31:0] vs_r, vt_r, mrd_r;
  out_word_t   res_r;
  logic        busy_out_r;
  logic [63:0] prod_r;

  // Fields of the current word
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, ea, pc4, jt, pl_addr;
  assign op = cur_r.instr_word[31:26];
  assign fn = cur_r.instr_word[5:0];
  assign rs = cur_r.instr_word[25:21];
  assign rt = cur_r.instr_word[20:16];
  assign rd = cur_r.instr_word[15:11];
  assign sh = cur_r.instr_word[10:6];
  assign imm = cur_r.instr_word[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign ea = vs_r + simm;
  assign pc4 = pc_r + 32'd4;
  assign jt = (pc4 & PC_REGION_MASK) | {4'd0, cur_r.instr_word[25:0], 2'b00};
  assign pl_addr = {20'd0, cur_r.preload_addr[11:2], 2'b00};

  // Read address for memory: from queue head at issue time
  logic [31:0] qea;
  logic [31:0] qvs;
  assign qvs = (q_data.instr_word[25:21] == 5'd0) ? 32'd0 : gpr_r[q_data.instr_word[25:21]];
  assign qea = qvs + {{16{q_data.instr_word[15]}}, q_data.instr_word[15:0]};

  // Address check and access size
  logic [2:0]  nbytes;
  logic        bad;
  logic [32:0] ea_end;
  always_comb begin
    case (op) inside
      OP_LB, OP_LBU, OP_SB: nbytes = 3'd1;
      OP_LH, OP_LHU, OP_SH: nbytes = 3'd2;
      default: nbytes = 3'd4;
    endcase
    ea_end = {1'b0, ea} + {30'd0, nbytes};
    bad = (ea == 32'd0) || (ea_end > 33'(MEM_BYTES)) ||
          ((nbytes == 3'd2) && ea[0]) || ((nbytes == 3'd4) && (ea[1:0] != 2'b00));
  end

  // Load data extraction
  logic [31:0] ld_shift, ld_val;
  assign ld_shift = mrd_r >> {ea[1:0], 3'b000};
  always_comb begin
    case (op)
      OP_LB:  ld_val = {{24{ld_shift[7]}}, ld_shift[7:0]};
      OP_LBU: ld_val = {24'd0, ld_shift[7:0]};
      OP_LH:  ld_val = {{16{ld_shift[15]}}, ld_shift[15:0]};
      OP_LHU: ld_val = {16'd0, ld_shift[15:0]};
      default: ld_val = mrd_r;
    endcase
  end

  // Compute result of current word
  out_word_t   r;
  logic [31:0] wv;
  logic        wr;
  logic [4:0]  wi;
  logic [31:0] sra_v;
  always_comb begin
    sra_v = $unsigned($signed(vt_r) >>> sh);
    r = '0;
    r.status = ST_OK;
    r.next_pc = pc4;
    wr = 1'b0;
    wi = rt;
    wv = 32'd0;
    case (cur_r.kind)
      K_PRELOAD: begin
        r.next_pc = pc_r;
        if (32'({cur_r.preload_addr[11:2], 2'b00}) + 32'd4 > 32'(MEM_BYTES)) begin
          r.status = ST_BADADDR;
        end
      end
      K_SETPC: r.next_pc = cur_r.preload_data;
      K_NOP: r.next_pc = pc_r;
      K_ILLEGAL: begin
        r.status = ST_ILLEGAL;
        r.next_pc = pc_r;
      end
      K_SYSCALL: r.status = ST_SYSCALL;
      K_MULT: r.next_pc = pc4;
      K_JUMP: begin
        if (op == OP_SPECIAL) begin
          r.next_pc = vs_r;
        end else begin
          r.next_pc = jt;
          if (op == OP_JAL) begin
            wr = 1'b1;
            wi = 5'd31;
            wv = pc4;
          end
        end
      end
      K_BRANCH: begin
        if ((op == OP_BEQ) == (vs_r == vt_r)) r.next_pc = pc4 + {simm[29:0], 2'b00};
      end
      K_ALU: begin
        wr = 1'b1;
        if (op == OP_SPECIAL) begin
          wi = rd;
          case (fn)
            FN_AND:  wv = vs_r & vt_r;
            FN_OR:   wv = vs_r | vt_r;
            FN_XOR:  wv = vs_r ^ vt_r;
            FN_NOR:  wv = ~(vs_r | vt_r);
            FN_ADDU: wv = vs_r + vt_r;
            FN_SUBU: wv = vs_r - vt_r;
            FN_SLT:  wv = {31'd0, $signed(vs_r) < $signed(vt_r)};
            FN_SLTU: wv = {31'd0, vs_r < vt_r};
            FN_SLL:  wv = vt_r << sh;
            FN_SRL:  wv = vt_r >> sh;
            FN_SRA:  wv = sra_v;
            FN_JALR: begin
              wv = pc4;
              r.next_pc = vs_r;
            end
            FN_MFHI: wv = hi_r;
            FN_MFLO: wv = lo_r;
            default: wv = 32'd0;
          endcase
        end else begin
          case (op)
            OP_ADDIU: wv = vs_r + simm;
            OP_SLTI:  wv = {31'd0, $signed(vs_r) < $signed(simm)};
            OP_SLTIU: wv = {31'd0, vs_r < simm};
            OP_ANDI:  wv = vs_r & {16'd0, imm};
            OP_ORI:   wv = vs_r | {16'd0, imm};
            OP_XORI:  wv = vs_r ^ {16'd0, imm};
            OP_LUI:   wv = {imm, 16'd0};
            default:  wv = 32'd0;
          endcase
        end
      end
      K_LOAD: begin
        if (bad) begin
          r.status = ST_BADADDR;
          r.next_pc = pc_r;
        end else begin
          wr = 1'b1;
          wv = ld_val;
        end
      end
      K_STORE: begin
        if (bad) begin
          r.status = ST_BADADDR;
          r.next_pc = pc_r;
        end else begin
          r.store_en = 1'b1;
          r.store_addr = ea[11:0];
          r.store_data = vt_r;
          r.store_size = nbytes;
        end
      end
      default: r.next_pc = pc_r;
    endcase
    if (wr && wi != 5'd0) begin
      r.reg_write_en = 1'b1;
      r.reg_index = wi;
      r.reg_value = wv;
    end
  end

  // Byte-lane store merge
  logic [31:0] st_word;
  logic [3:0]  st_be;
  always_comb begin
    st_word = vt_r << {ea[1:0], 3'b000};
    case (nbytes)
      3'd1: st_be = 4'b0001 << ea[1:0];
      3'd2: st_be = 4'b0011 << ea[1:0];
      default: st_be = 4'b1111;
    endcase
  end

  // Multiplier operands, signed when MULT
  logic signed [32:0] ma, mb;
  assign ma = {(fn == FN_MULT) & vs_r[31], vs_r};
  assign mb = {(fn == FN_MULT) & vt_r[31], vt_r};

  // Issue when the output register is free or drains this cycle
  assign q_pop = (state_r == S_IDLE) && q_valid && (!busy_out_r || out_ready);
  assign out_valid = busy_out_r;
  assign out_data = res_r;

  // Memory: one write port, one registered read port
  logic          mem_we;
  logic [WW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ea[AW-1:2];
    mem_wd = mrd_r;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_r[WW-1:0];
      mem_wd = 32'd0;
    end else if (state_r == S_EXEC && cur_r.kind == K_PRELOAD && r.status == ST_OK) begin
      mem_we = 1'b1;
      mem_wa = pl_addr[AW-1:2];
      mem_wd = cur_r.preload_data;
    end else if (state_r == S_EXEC && r.store_en) begin
      mem_we = 1'b1;
      mem_wd = {st_be[3] ? st_word[31:24] : mrd_r[31:24],
                st_be[2] ? st_word[23:16] : mrd_r[23:16],
                st_be[1] ? st_word[15:8]  : mrd_r[15:8],
                st_be[0] ? st_word[7:0]   : mrd_r[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= mem_wd;
    mrd_r <= mem_r[qea[AW-1:2]];
  end

  // Sequencer: clear memory after reset, then issue, execute or multiply, retire
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      pc_r <= 32'd0;
      hi_r <= 32'd0;
      lo_r <= 32'd0;
      busy_out_r <= 1'b0;
      for (int i = 0; i < 32; i++) gpr_r[i] <= 32'd0;
    end else begin
      if (busy_out_r && out_ready) busy_out_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (WW+1)'(WORDS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            cur_r <= q_data;
            vs_r <= qvs;
            vt_r <= (q_data.instr_word[20:16] == 5'd0) ? 32'd0 :
                    gpr_r[q_data.instr_word[20:16]];
            state_r <= (q_data.kind == K_MULT) ? S_MUL : S_EXEC;
          end
        end
        S_MUL: begin
          prod_r <= 64'(ma * mb);
          state_r <= S_OUT;
        end
        S_OUT: begin
          hi_r <= prod_r[63:32];
          lo_r <= prod_r[31:0];
          pc_r <= r.next_pc;
          res_r <= r;
          busy_out_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_EXEC: begin
          res_r <= r;
          busy_out_r <= 1'b1;
          pc_r <= r.next_pc;
          if (r.reg_write_en) gpr_r[r.reg_index] <= r.reg_value;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_r0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.reg_write_en && out_data.reg_index == 5'd0))
    else $error("write to register zero reported");
  a_fault_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && (r.status == ST_ILLEGAL || r.status == ST_BADADDR))
    |=> (pc_r == $past(pc_r))) else $error("fault moved PC");
  a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> !out_data.store_en)
    else $error("store on faulting word");

endmodule

>>> rtl/risc_instruction_execute_unit.sv
// Channel | handshake          | payload
// in      | in_valid/in_ready  | in_data  (in_word_t: mode, instr, preload addr/data)
// out     | out_valid/out_ready| out_data (out_word_t: status, pc, reg write, store)
// An item is issued with its register/memory read, then executed; mult/multu instead
// pass through the registered 33x33 multiplier stage before retiring. A two-entry queue sits
// between front and back. After reset the back end zeroes every memory word
// before the first item issues; the front still fills its queue meanwhile.
// Depends on rieu_pkg, rieu_front, rieu_back.
module risc_instruction_execute_unit import rieu_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic      q_valid, q_pop;
  dec_word_t q_data;

  // Classify and queue
  rieu_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_pop, .q_data
  );

  // Execute and retire
  rieu_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .out_valid, .out_ready, .out_data
  );

endmodule
